// ----- hw/rtl/rmf_pkg.sv -----
// Package for the running median filter.
// Holds fixed widths, the sequencer state type and the control structs.
// No dependencies.
package rmf_pkg;

  localparam int unsigned SampleW     = 12;
  localparam int unsigned WinW        = 5;
  localparam int unsigned WindowReset = 5;
  localparam int unsigned StepW       = $clog2(SampleW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic wr;
    logic rot;
  } ring_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sel_stat_t;

endpackage

// ----- hw/rtl/rmf_sample_if.sv -----
// Valid/ready channel carrying one input sample word.
// Depends on rmf_pkg.
interface rmf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [rmf_pkg::SampleW-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- hw/rtl/rmf_median_if.sv -----
// Valid/ready channel carrying one median result word.
// Depends on rmf_pkg.
interface rmf_median_if;
  logic                          valid;
  logic                          ready;
  logic [rmf_pkg::SampleW-1:0]   median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ----- hw/rtl/rmf_ring.sv -----
// Sample store: one circular shift register per ring slot, MSB tap exposed.
// Written at one slot, rotated one bit per cycle during a scan. Depends on rmf_pkg.
module rmf_ring #(
  parameter int unsigned Entries = 16,
  parameter int unsigned AddrW   = 4
) (
  input  logic                        clk_i,
  input  rmf_pkg::ring_ctl_t          ctl_i,
  input  logic [AddrW-1:0]            addr_i,
  input  logic [rmf_pkg::SampleW-1:0] data_i,
  output logic [Entries-1:0]          msb_o
);

  logic [rmf_pkg::SampleW-1:0] slot_q [Entries];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Entries; i++) begin
      if (ctl_i.rot) begin
        slot_q[i] <= {slot_q[i][rmf_pkg::SampleW-2:0], slot_q[i][rmf_pkg::SampleW-1]};
      end else if (ctl_i.wr && (addr_i == AddrW'(i))) begin
        slot_q[i] <= data_i;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      msb_o[i] = slot_q[i][rmf_pkg::SampleW-1];
    end
  end

endmodule

// ----- hw/rtl/rmf_select.sv -----
// Bit-serial rank selector: one result bit per cycle, MSB first, by
// narrowing a candidate mask. Depends on rmf_pkg.
module rmf_select #(
  parameter int unsigned Entries = 16,
  parameter int unsigned CntW    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CntW-1:0]             count_i,
  input  logic [Entries-1:0]          msb_i,
  output rmf_pkg::sel_stat_t          stat_o,
  output logic [rmf_pkg::SampleW-1:0] median_o
);

  logic [Entries-1:0]            mask_q, mask_d;
  logic [CntW-1:0]               rank_q, rank_d;
  logic [rmf_pkg::SampleW-1:0]   res_q, res_d;
  logic [rmf_pkg::StepW-1:0]     step_q, step_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               zeros;
  logic                          bit_one;

  always_comb begin
    zeros = '0;
    for (int i = 0; i < Entries; i++) begin
      zeros = zeros + CntW'(mask_q[i] & ~msb_i[i]);
    end
    bit_one = (rank_q >= zeros);
  end

  always_comb begin
    mask_d = mask_q;
    rank_d = rank_q;
    res_d  = res_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      for (int i = 0; i < Entries; i++) begin
        mask_d[i] = (CntW'(i) < count_i);
      end
      rank_d = count_i >> 1;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      res_d = {res_q[rmf_pkg::SampleW-2:0], bit_one};
      if (bit_one) begin
        rank_d = rank_q - zeros;
        mask_d = mask_q & msb_i;
      end else begin
        mask_d = mask_q & ~msb_i;
      end
      step_d = step_q + 1'b1;
      if (step_q == rmf_pkg::StepW'(rmf_pkg::SampleW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    rank_q <= rank_d;
    res_q  <= res_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign median_o    = res_q;

endmodule

// ----- hw/rtl/running_median_filter.sv -----
// Running median filter, top level: window register, ring pointers, sequencer.
// Depends on rmf_pkg, rmf_sample_if, rmf_median_if, rmf_ring, rmf_select.
//
// Usage:
//   sample_i is a valid/ready sink of 12-bit sample words; median_o is a
//   valid/ready source of 12-bit median words, one per sample.
//   The window register (cfg_we_i/cfg_wdata_i) is clamped to 1..MAX_SAMPLES
//   and restarts the filter (write slot and fill count cleared).
//   Result is the sample of rank count/2 (upper median) over the filled slots.
// Timing:
//   A word is taken in ST_IDLE, then the selector resolves one result bit
//   per cycle, MSB first, and raises done; the result is then loaded into
//   the output register and the sequencer returns to idle, so no new word
//   is taken until the current median has been loaded. The bit-serial
//   selector (a popcount over the candidate MSB taps each cycle) sets the rate.
// Reset: window 5, ring empty, output invalid.
// Stall: a finished median waits in the output register; a second finished
//   median holds the block until the first is taken.
module running_median_filter #(
  parameter int unsigned MAX_SAMPLES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rmf_pkg::WinW-1:0]  cfg_wdata_i,
  rmf_sample_if.sink                sample_i,
  rmf_median_if.source              median_o
);

  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AddrW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned WinRst =
    (rmf_pkg::WindowReset > MAX_SAMPLES) ? MAX_SAMPLES : rmf_pkg::WindowReset;

  rmf_pkg::state_e             state_q, state_d;
  logic [CntW-1:0]             window_q, window_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [AddrW-1:0]            wp_q, wp_d;
  logic [AddrW-1:0]            wp_eff;
  logic [CntW-1:0]             wp_inc;
  logic                        out_valid_q;
  logic [rmf_pkg::SampleW-1:0] out_data_q;
  logic                        accept;
  logic                        out_free;
  logic                        load_out;
  rmf_pkg::ring_ctl_t          ring_ctl;
  rmf_pkg::sel_stat_t          sel_stat;
  logic [MAX_SAMPLES-1:0]      msb;
  logic [rmf_pkg::SampleW-1:0] sel_median;

  assign accept   = sample_i.valid && sample_i.ready;
  assign out_free = !out_valid_q || median_o.ready;

  // window clamp
  always_comb begin
    window_d = window_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        window_d = CntW'(1);
      end else if (int'(cfg_wdata_i) > int'(MAX_SAMPLES)) begin
        window_d = CntW'(MAX_SAMPLES);
      end else begin
        window_d = CntW'(cfg_wdata_i);
      end
    end
  end

  always_comb begin
    wp_eff = (CntW'(wp_q) >= window_q) ? '0 : wp_q;
    wp_inc = CntW'(wp_eff) + 1'b1;
    wp_d   = wp_q;
    fill_d = fill_q;
    if (cfg_we_i) begin
      wp_d   = '0;
      fill_d = '0;
    end else if (accept) begin
      wp_d   = (wp_inc >= window_q) ? '0 : AddrW'(wp_inc);
      fill_d = (fill_q < window_q) ? fill_q + 1'b1 : window_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmf_pkg::ST_IDLE: begin
        if (accept) state_d = rmf_pkg::ST_SCAN;
      end
      rmf_pkg::ST_SCAN: begin
        if (sel_stat.done) state_d = out_free ? rmf_pkg::ST_IDLE : rmf_pkg::ST_HOLD;
      end
      rmf_pkg::ST_HOLD: begin
        if (out_free) state_d = rmf_pkg::ST_IDLE;
      end
      default: state_d = rmf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sample_i.ready = 1'b0;
    load_out       = 1'b0;
    case (state_q)
      rmf_pkg::ST_IDLE: sample_i.ready = 1'b1;
      rmf_pkg::ST_SCAN: load_out = sel_stat.done && out_free;
      rmf_pkg::ST_HOLD: load_out = out_free;
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmf_pkg::ST_IDLE;
      window_q    <= CntW'(WinRst);
      fill_q      <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      window_q <= window_d;
      fill_q   <= fill_d;
      wp_q     <= wp_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (median_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_data_q <= sel_median;
  end

  assign median_o.valid  = out_valid_q;
  assign median_o.median = out_data_q;

  assign ring_ctl.wr  = accept;
  assign ring_ctl.rot = sel_stat.busy;

  rmf_ring #(
    .Entries (MAX_SAMPLES),
    .AddrW   (AddrW)
  ) u_ring (
    .clk_i  (clk_i),
    .ctl_i  (ring_ctl),
    .addr_i (wp_eff),
    .data_i (sample_i.sample),
    .msb_o  (msb)
  );

  rmf_select #(
    .Entries (MAX_SAMPLES),
    .CntW    (CntW)
  ) u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .count_i  (fill_d),
    .msb_i    (msb),
    .stat_o   (sel_stat),
    .median_o (sel_median)
  );

  a_fill_le_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= window_q)
    else $error("fill count above window");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> sel_stat.busy && state_q == rmf_pkg::ST_SCAN)
    else $error("scan did not start after accept");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.ready |-> !sel_stat.busy && !sel_stat.done)
    else $error("input ready while selector active");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_stat.done |=> !sel_stat.done)
    else $error("selector done longer than one cycle");

endmodule
